FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the histogram core modules.
// Expects clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

// antecedent at an edge requires consequent at the same edge
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/lwh_pkg.sv
// Shared types, codes and width helpers for the linear weighted histogram core.
// No dependencies.
package lwh_pkg;

    localparam int NUM_BINS_DEF  = 256;
    localparam int FRAC_BITS_DEF = 16;
    localparam int QUEUE_DEPTH   = 4;

    localparam int ACC_W      = 48;
    localparam int SAMPLE_W   = 32;
    localparam int INDEX_W    = 8;
    localparam int CMD_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 48;

    localparam logic [ACC_W-1:0] ACC_MAX = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_ACCUM = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_READ  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        OP_ACCUM = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2
    } op_kind_t;

    localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BIN_SCALE  = 2'd2;

    localparam logic [CFG_DATA_W-1:0] RANGE_LOW_RST  = 32'h0000_0000;
    localparam logic [CFG_DATA_W-1:0] RANGE_HIGH_RST = 32'h7FFF_FFFF;
    localparam logic [CFG_DATA_W-1:0] BIN_SCALE_RST  = 32'h0001_0000;

    typedef struct packed {
        op_kind_t kind;
        logic     in_range;
        logic     batch_done;
    } op_ctrl_t;

    localparam int OP_CTRL_W = $bits(op_ctrl_t);

    function automatic int bank_addr_w(input int num_bins);
        int depth;
        depth = (num_bins + 1) / 2;
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

    // op layout: ctrl, even {en, addr, weight}, odd {en, addr, weight}
    function automatic int op_w(input int num_bins, input int frac_bits);
        return OP_CTRL_W + 2 * (1 + bank_addr_w(num_bins) + frac_bits + 1);
    endfunction

endpackage

FILE: rtl/core/linear_weighted_histogram_core.sv
// An accepted input beat passes front stages s1, s2, s3, the op queue, back stage
// b2 and the output register. Throughput: one accumulate or read beat per cycle
// unless m_tready or a full queue stalls; a clear holds the back end while both
// bin banks are zeroed one row per cycle. Reset: asynchronous, active low;
// afterwards s_tready stays low while the banks are swept to zero.
// Top level: lwh_front -> lwh_queue -> lwh_back; depends on lwh_pkg.
module linear_weighted_histogram_core #(
    parameter int NUM_BINS  = lwh_pkg::NUM_BINS_DEF,
    parameter int FRAC_BITS = lwh_pkg::FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lwh_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lwh_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [lwh_pkg::S_TDATA_W-1:0]   s_tdata,  // sample_value[31:0], bin_index[39:32]
    input  logic                            s_tlast,  // last_sample
    input  logic [lwh_pkg::CMD_W-1:0]       s_tuser,  // command[1:0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lwh_pkg::M_TDATA_W-1:0]   m_tdata,  // bin_value[47:0]
    output logic                            m_tlast,  // batch_done
    output logic                            m_tuser   // in_range
);

    localparam int OP_W = lwh_pkg::op_w(NUM_BINS, FRAC_BITS);

    logic            init_done;
    logic            q_full;
    logic            q_empty;
    logic            q_push;
    logic            q_pop;
    logic [OP_W-1:0] q_in;
    logic [OP_W-1:0] q_head;

    lwh_front #(
        .NUM_BINS  (NUM_BINS),
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .init_done (init_done),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_in)
    );

    lwh_queue #(
        .W     (OP_W),
        .DEPTH (lwh_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .head_data (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    lwh_back #(
        .NUM_BINS  (NUM_BINS),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_data    (q_head),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .init_done (init_done),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

FILE: rtl/core/lwh_front.sv
// Front end: configuration registers, input beat acceptance, range check,
// bin position multiply and split of each sample into even/odd bank updates.
// Depends on lwh_pkg.
module lwh_front #(
    parameter int NUM_BINS  = lwh_pkg::NUM_BINS_DEF,
    parameter int FRAC_BITS = lwh_pkg::FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lwh_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lwh_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [lwh_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                            s_tlast,
    input  logic [lwh_pkg::CMD_W-1:0]       s_tuser,
    input  logic                            init_done,
    input  logic                            q_full,
    output logic                            q_push,
    output logic [lwh_pkg::op_w(NUM_BINS, FRAC_BITS)-1:0] q_data
);

    localparam int BIW  = $clog2(NUM_BINS);
    localparam int AW   = lwh_pkg::bank_addr_w(NUM_BINS);
    localparam int WW   = FRAC_BITS + 1;
    localparam int OP_W = lwh_pkg::op_w(NUM_BINS, FRAC_BITS);
    localparam int SW   = lwh_pkg::SAMPLE_W;
    localparam logic [BIW-1:0] LAST_BIN = BIW'(NUM_BINS - 1);
    localparam logic [WW-1:0]  ONE_W    = {1'b1, {FRAC_BITS{1'b0}}};

    logic [SW-1:0] range_low_reg;
    logic [SW-1:0] range_high_reg;
    logic [SW-1:0] bin_scale_reg;

    logic [SW-1:0]                 in_sample;
    logic [lwh_pkg::INDEX_W-1:0]   in_index;
    logic [SW:0]                   diff_full;
    logic                          in_ge;
    logic                          in_le;
    logic                          fe_adv;
    logic                          accept;

    logic                          s1_valid_reg;
    logic [lwh_pkg::CMD_W-1:0]     s1_cmd_reg;
    logic [lwh_pkg::INDEX_W-1:0]   s1_idx_reg;
    logic                          s1_last_reg;
    logic                          s1_inr_reg;
    logic [SW-1:0]                 s1_diff_reg;

    logic                          s2_valid_reg;
    logic [lwh_pkg::CMD_W-1:0]     s2_cmd_reg;
    logic [lwh_pkg::INDEX_W-1:0]   s2_idx_reg;
    logic                          s2_last_reg;
    logic                          s2_inr_reg;
    logic [2*SW-1:0]               s2_pos_reg;

    logic                          s3_valid_reg;
    logic [OP_W-1:0]               s3_op_reg;
    logic [OP_W-1:0]               s3_op_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_low_reg  <= lwh_pkg::RANGE_LOW_RST;
            range_high_reg <= lwh_pkg::RANGE_HIGH_RST;
            bin_scale_reg  <= lwh_pkg::BIN_SCALE_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                lwh_pkg::REG_RANGE_LOW:  range_low_reg  <= cfg_data;
                lwh_pkg::REG_RANGE_HIGH: range_high_reg <= cfg_data;
                lwh_pkg::REG_BIN_SCALE:  bin_scale_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign in_sample = s_tdata[SW-1:0];
    assign in_index  = s_tdata[SW +: lwh_pkg::INDEX_W];
    assign diff_full = {in_sample[SW-1], in_sample} - {range_low_reg[SW-1], range_low_reg};
    assign in_ge     = !diff_full[SW];
    assign in_le     = $signed(in_sample) <= $signed(range_high_reg);

    assign fe_adv   = !s3_valid_reg || !q_full;
    assign s_tready = fe_adv && init_done;
    assign accept   = s_tvalid && s_tready;
    assign q_push   = s3_valid_reg && !q_full;
    assign q_data   = s3_op_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (fe_adv)
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fe_adv)
        begin
            s1_cmd_reg  <= s_tuser;
            s1_idx_reg  <= in_index;
            s1_last_reg <= s_tlast;
            s1_inr_reg  <= in_ge && in_le;
            s1_diff_reg <= diff_full[SW-1:0];
            s2_cmd_reg  <= s1_cmd_reg;
            s2_idx_reg  <= s1_idx_reg;
            s2_last_reg <= s1_last_reg;
            s2_inr_reg  <= s1_inr_reg;
            s2_pos_reg  <= (2*SW)'(s1_diff_reg) * (2*SW)'(bin_scale_reg);
            s3_op_reg   <= s3_op_next;
        end
    end

    function automatic logic [AW-1:0] bin_addr(input logic [BIW-1:0] b);
        logic [31:0] t;
        t = 32'(b) >> 1;
        return t[AW-1:0];
    endfunction

    logic [2*SW-1:0]        left;
    logic [FRAC_BITS-1:0]   frac;
    logic [BIW-1:0]         lo_bin;
    logic [BIW-1:0]         hi_bin;
    logic [WW-1:0]          lo_w;
    logic [WW-1:0]          hi_w;
    logic                   hi_en;
    logic [31:0]            rd_addr_full;
    lwh_pkg::op_ctrl_t      ctrl;
    logic                   e_en;
    logic [AW-1:0]          e_addr;
    logic [WW-1:0]          e_w;
    logic                   o_en;
    logic [AW-1:0]          o_addr;
    logic [WW-1:0]          o_w;

    always_comb
    begin
        left         = s2_pos_reg >> (2 * FRAC_BITS);
        frac         = s2_pos_reg[2*FRAC_BITS-1:FRAC_BITS];
        rd_addr_full = 32'(s2_idx_reg) >> 1;
        if (left >= (2*SW)'(NUM_BINS - 1))
        begin
            lo_bin = LAST_BIN;
            hi_bin = LAST_BIN;
            lo_w   = ONE_W;
            hi_w   = '0;
            hi_en  = 1'b0;
        end
        else
        begin
            lo_bin = left[BIW-1:0];
            hi_bin = left[BIW-1:0] + 1'b1;
            lo_w   = ONE_W - WW'(frac);
            hi_w   = WW'(frac);
            hi_en  = 1'b1;
        end

        ctrl.kind       = lwh_pkg::OP_READ;
        ctrl.in_range   = 1'b0;
        ctrl.batch_done = 1'b0;
        e_en   = 1'b0;
        e_addr = '0;
        e_w    = '0;
        o_en   = 1'b0;
        o_addr = '0;
        o_w    = '0;

        case (s2_cmd_reg)
            lwh_pkg::CMD_ACCUM:
            begin
                ctrl.kind       = lwh_pkg::OP_ACCUM;
                ctrl.in_range   = s2_inr_reg;
                ctrl.batch_done = s2_last_reg;
                if (s2_inr_reg)
                begin
                    if (!lo_bin[0])
                    begin
                        e_en   = 1'b1;
                        e_addr = bin_addr(lo_bin);
                        e_w    = lo_w;
                        o_en   = hi_en;
                        o_addr = bin_addr(hi_bin);
                        o_w    = hi_w;
                    end
                    else
                    begin
                        o_en   = 1'b1;
                        o_addr = bin_addr(lo_bin);
                        o_w    = lo_w;
                        e_en   = hi_en;
                        e_addr = bin_addr(hi_bin);
                        e_w    = hi_w;
                    end
                end
            end
            lwh_pkg::CMD_CLEAR:
            begin
                ctrl.kind = lwh_pkg::OP_CLEAR;
            end
            lwh_pkg::CMD_READ:
            begin
                if (32'(s2_idx_reg) < 32'(NUM_BINS))
                begin
                    e_en   = !s2_idx_reg[0];
                    o_en   = s2_idx_reg[0];
                    e_addr = rd_addr_full[AW-1:0];
                    o_addr = rd_addr_full[AW-1:0];
                end
            end
            default: ;
        endcase

        s3_op_next = {ctrl, e_en, e_addr, e_w, o_en, o_addr, o_w};
    end

endmodule

FILE: rtl/core/lwh_queue.sv
// Short first-in first-out queue of bank operations between front and back end.
// Depends on lwh_pkg for its default depth and on assert_macros.svh.
`include "assert_macros.svh"

module lwh_queue #(
    parameter int W     = 8,
    parameter int DEPTH = lwh_pkg::QUEUE_DEPTH
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    input  logic         pop,
    output logic [W-1:0] head_data,
    output logic         full,
    output logic         empty
);

    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [W-1:0]  entries_reg [DEPTH];
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] wr_ptr_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    assign full      = count_reg == FULL_CNT;
    assign empty     = count_reg == '0;
    assign head_data = entries_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

    `ASSERT_NEVER(a_q_overflow, push && full, "push into full op queue")
    `ASSERT_NEVER(a_q_underflow, pop && empty, "pop from empty op queue")

endmodule

FILE: rtl/core/lwh_back.sv
// Back end: even/odd bin banks with read-modify-write, write forwarding,
// clearing sweep and the registered output beat.
// Depends on lwh_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lwh_back #(
    parameter int NUM_BINS  = lwh_pkg::NUM_BINS_DEF,
    parameter int FRAC_BITS = lwh_pkg::FRAC_BITS_DEF
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic [lwh_pkg::op_w(NUM_BINS, FRAC_BITS)-1:0] q_data,
    input  logic                                          q_empty,
    output logic                                          q_pop,
    output logic                                          init_done,
    output logic                                          m_tvalid,
    input  logic                                          m_tready,
    output logic [lwh_pkg::M_TDATA_W-1:0]                 m_tdata,
    output logic                                          m_tlast,
    output logic                                          m_tuser
);

    localparam int BANK_DEPTH = (NUM_BINS + 1) / 2;
    localparam int AW         = lwh_pkg::bank_addr_w(NUM_BINS);
    localparam int WW         = FRAC_BITS + 1;
    localparam int ACC_W      = lwh_pkg::ACC_W;
    localparam int SUM_W      = ACC_W + 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(BANK_DEPTH - 1);

    logic [ACC_W-1:0] mem_e [BANK_DEPTH];
    logic [ACC_W-1:0] mem_o [BANK_DEPTH];

    lwh_pkg::op_ctrl_t h_ctrl;
    logic              h_e_en;
    logic [AW-1:0]     h_e_addr;
    logic [WW-1:0]     h_e_w;
    logic              h_o_en;
    logic [AW-1:0]     h_o_addr;
    logic [WW-1:0]     h_o_w;

    logic              b2_valid_reg;
    lwh_pkg::op_ctrl_t b2_ctrl_reg;
    logic              b2_e_en_reg;
    logic [AW-1:0]     b2_e_addr_reg;
    logic [WW-1:0]     b2_e_w_reg;
    logic              b2_o_en_reg;
    logic [AW-1:0]     b2_o_addr_reg;
    logic [WW-1:0]     b2_o_w_reg;
    logic [ACC_W-1:0]  rd_e_reg;
    logic [ACC_W-1:0]  rd_o_reg;
    logic              fwd_e_hit_reg;
    logic              fwd_o_hit_reg;
    logic [ACC_W-1:0]  fwd_e_data_reg;
    logic [ACC_W-1:0]  fwd_o_data_reg;

    logic              sweep_active_reg;
    logic [AW-1:0]     sweep_cnt_reg;
    logic              init_done_reg;

    logic              m_tvalid_reg;
    logic [ACC_W-1:0]  m_tdata_reg;
    logic              m_tlast_reg;
    logic              m_tuser_reg;

    logic [ACC_W-1:0]  cur_e;
    logic [ACC_W-1:0]  cur_o;
    logic [SUM_W-1:0]  sum_e;
    logic [SUM_W-1:0]  sum_o;
    logic [ACC_W-1:0]  new_e;
    logic [ACC_W-1:0]  new_o;
    logic [ACC_W-1:0]  rd_value;
    logic              b2_done;
    logic              out_free;
    logic              commit;
    logic              be_adv;
    logic              acc_wr;
    logic              cw_e;
    logic              cw_o;
    logic              we_e;
    logic              we_o;
    logic [AW-1:0]     wa_e;
    logic [AW-1:0]     wa_o;
    logic [ACC_W-1:0]  wd_e;
    logic [ACC_W-1:0]  wd_o;

    assign {h_ctrl, h_e_en, h_e_addr, h_e_w, h_o_en, h_o_addr, h_o_w} = q_data;

    assign cur_e = fwd_e_hit_reg ? fwd_e_data_reg : rd_e_reg;
    assign cur_o = fwd_o_hit_reg ? fwd_o_data_reg : rd_o_reg;
    assign sum_e = {1'b0, cur_e} + SUM_W'(b2_e_w_reg);
    assign sum_o = {1'b0, cur_o} + SUM_W'(b2_o_w_reg);
    assign new_e = sum_e[ACC_W] ? lwh_pkg::ACC_MAX : sum_e[ACC_W-1:0];
    assign new_o = sum_o[ACC_W] ? lwh_pkg::ACC_MAX : sum_o[ACC_W-1:0];

    assign b2_done  = (b2_ctrl_reg.kind != lwh_pkg::OP_CLEAR) || !sweep_active_reg;
    assign out_free = !m_tvalid_reg || m_tready;
    assign commit   = b2_valid_reg && b2_done && out_free;
    assign be_adv   = !b2_valid_reg || commit;
    assign q_pop    = !q_empty && be_adv && init_done_reg;

    assign acc_wr = commit && (b2_ctrl_reg.kind == lwh_pkg::OP_ACCUM);
    assign cw_e   = acc_wr && b2_e_en_reg;
    assign cw_o   = acc_wr && b2_o_en_reg;
    assign we_e   = sweep_active_reg || cw_e;
    assign we_o   = sweep_active_reg || cw_o;
    assign wa_e   = sweep_active_reg ? sweep_cnt_reg : b2_e_addr_reg;
    assign wa_o   = sweep_active_reg ? sweep_cnt_reg : b2_o_addr_reg;
    assign wd_e   = sweep_active_reg ? '0 : new_e;
    assign wd_o   = sweep_active_reg ? '0 : new_o;

    always_comb
    begin
        rd_value = '0;
        if (b2_ctrl_reg.kind == lwh_pkg::OP_READ)
        begin
            if (b2_e_en_reg)
            begin
                rd_value = cur_e;
            end
            else if (b2_o_en_reg)
            begin
                rd_value = cur_o;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (we_e)
        begin
            mem_e[wa_e] <= wd_e;
        end
        if (q_pop)
        begin
            rd_e_reg <= mem_e[h_e_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (we_o)
        begin
            mem_o[wa_o] <= wd_o;
        end
        if (q_pop)
        begin
            rd_o_reg <= mem_o[h_o_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b2_valid_reg     <= 1'b0;
            fwd_e_hit_reg    <= 1'b0;
            fwd_o_hit_reg    <= 1'b0;
            sweep_active_reg <= 1'b1;
            sweep_cnt_reg    <= '0;
            init_done_reg    <= 1'b0;
            m_tvalid_reg     <= 1'b0;
        end
        else
        begin
            if (be_adv)
            begin
                b2_valid_reg <= q_pop;
            end
            if (q_pop)
            begin
                fwd_e_hit_reg <= cw_e && (b2_e_addr_reg == h_e_addr);
                fwd_o_hit_reg <= cw_o && (b2_o_addr_reg == h_o_addr);
            end
            if (q_pop && (h_ctrl.kind == lwh_pkg::OP_CLEAR))
            begin
                sweep_active_reg <= 1'b1;
                sweep_cnt_reg    <= '0;
            end
            else if (sweep_active_reg)
            begin
                if (sweep_cnt_reg == LAST_ADDR)
                begin
                    sweep_active_reg <= 1'b0;
                    init_done_reg    <= 1'b1;
                end
                else
                begin
                    sweep_cnt_reg <= sweep_cnt_reg + 1'b1;
                end
            end
            if (commit)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            b2_ctrl_reg    <= h_ctrl;
            b2_e_en_reg    <= h_e_en;
            b2_e_addr_reg  <= h_e_addr;
            b2_e_w_reg     <= h_e_w;
            b2_o_en_reg    <= h_o_en;
            b2_o_addr_reg  <= h_o_addr;
            b2_o_w_reg     <= h_o_w;
            fwd_e_data_reg <= new_e;
            fwd_o_data_reg <= new_o;
        end
        if (commit)
        begin
            m_tdata_reg <= rd_value;
            m_tlast_reg <= b2_ctrl_reg.batch_done;
            m_tuser_reg <= b2_ctrl_reg.in_range;
        end
    end

    assign init_done = init_done_reg;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tlast   = m_tlast_reg;
    assign m_tuser   = m_tuser_reg;

    `ASSERT_NEVER(a_sweep_write_clash, sweep_active_reg && (cw_e || cw_o), "bank update during sweep")
    `ASSERT_IMPLY(a_read_one_bank, b2_valid_reg && (b2_ctrl_reg.kind == lwh_pkg::OP_READ), !(b2_e_en_reg && b2_o_en_reg), "read selects both banks")
    `ASSERT_IMPLY(a_pop_after_init, !init_done_reg, !b2_valid_reg && !m_tvalid_reg, "op in flight before banks zeroed")

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for linear_weighted_histogram_core: drives sample,
// clear and read beats, predicts every result beat and compares it field by field.
// Depends on lwh_pkg and the core RTL only.
`timescale 1ns / 100ps

module testbench;
    import lwh_pkg::*;

    localparam int NB = NUM_BINS_DEF;
    localparam int FB = FRAC_BITS_DEF;
    localparam logic [ACC_W-1:0] FULL_WEIGHT = ACC_W'(1) << FB;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = NB / 2 + 16;

    typedef struct packed {
        logic             in_range;
        logic [ACC_W-1:0] bin_value;
        logic             batch_done;
    } hist_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;  // sample_value[31:0], bin_index[39:32]
    logic                  s_tlast;  // last_sample
    logic [CMD_W-1:0]      s_tuser;  // command[1:0]
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;  // bin_value[47:0]
    logic                  m_tlast;  // batch_done
    logic                  m_tuser;  // in_range

    linear_weighted_histogram_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    logic [ACC_W-1:0]      bin_totals [NB];
    logic [CFG_DATA_W-1:0] range_low_reg;
    logic [CFG_DATA_W-1:0] range_high_reg;
    logic [CFG_DATA_W-1:0] bin_scale_reg;
    hist_result_t          pending_results [$];

    int send_idle_pct;
    int recv_stall_pct;
    int fail_count;
    int beats_sent;
    int results_checked;
    int samples_binned;
    int samples_dropped;
    int reads_sent;
    int clears_sent;
    int configs_written;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic void add_weight(int unsigned bin, logic [ACC_W-1:0] weight);
        logic [ACC_W:0] sum;
        sum = {1'b0, bin_totals[bin]} + {1'b0, weight};
        bin_totals[bin] = (sum > {1'b0, ACC_MAX}) ? ACC_MAX : sum[ACC_W-1:0];
    endfunction

    function automatic hist_result_t predict_histogram(logic [CMD_W-1:0] cmd,
                                                       logic [SAMPLE_W-1:0] sample,
                                                       logic [INDEX_W-1:0] idx,
                                                       logic last);
        hist_result_t     res;
        longint           x;
        longint           lo;
        longint           hi;
        logic [63:0]      pos;
        logic [63:0]      left;
        logic [FB-1:0]    frac;
        res = '0;
        if (cmd == CMD_ACCUM)
        begin
            x = longint'($signed(sample));
            lo = longint'($signed(range_low_reg));
            hi = longint'($signed(range_high_reg));
            res.batch_done = last;
            if (x >= lo && x <= hi)
            begin
                res.in_range = 1'b1;
                pos = 64'(x - lo) * {32'd0, bin_scale_reg};
                left = pos >> (2 * FB);
                frac = pos[2*FB-1:FB];
                if (left >= 64'(NB - 1))
                    add_weight(NB - 1, FULL_WEIGHT);
                else
                begin
                    add_weight(int'(left), FULL_WEIGHT - ACC_W'(frac));
                    add_weight(int'(left) + 1, ACC_W'(frac));
                end
            end
        end
        else if (cmd == CMD_CLEAR)
        begin
            foreach (bin_totals[i])
                bin_totals[i] = '0;
        end
        else if (cmd == CMD_READ)
        begin
            if (int'(idx) < NB)
                res.bin_value = bin_totals[idx];
        end
        return res;
    endfunction

    task automatic send_beat(logic [CMD_W-1:0] cmd, logic [SAMPLE_W-1:0] sample,
                             logic [INDEX_W-1:0] idx, logic last);
        hist_result_t res;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {idx, sample};
        s_tlast  <= last;
        s_tuser  <= cmd;
        do
            @(posedge clk);
        while (!s_tready);
        res = predict_histogram(cmd, sample, idx, last);
        pending_results.push_back(res);
        beats_sent++;
        if (cmd == CMD_ACCUM && res.in_range)
            samples_binned++;
        if (cmd == CMD_ACCUM && !res.in_range)
            samples_dropped++;
        if (cmd == CMD_READ)
            reads_sent++;
        if (cmd == CMD_CLEAR)
            clears_sent++;
    endtask

    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(logic [CFG_DATA_W-1:0] low, logic [CFG_DATA_W-1:0] high,
                                logic [CFG_DATA_W-1:0] scale);
        logic [CFG_DATA_W-1:0] values [3];
        logic [CFG_IDX_W-1:0]  regs [3];
        values = '{low, high, scale};
        regs = '{REG_RANGE_LOW, REG_RANGE_HIGH, REG_BIN_SCALE};
        for (int i = 0; i < 3; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= values[i];
            do
                @(posedge clk);
            while (!cfg_ready);
            if (regs[i] == REG_RANGE_LOW)
                range_low_reg = values[i];
            else if (regs[i] == REG_RANGE_HIGH)
                range_high_reg = values[i];
            else
                bin_scale_reg = values[i];
        end
        cfg_valid <= 1'b0;
        configs_written++;
    endtask

    task automatic random_config();
        longint      lo;
        longint      hi;
        longint      span;
        logic [63:0] scale;
        lo = longint'($signed($urandom));
        span = longint'($urandom >> $urandom_range(0, 24)) + 1;
        hi = lo + span;
        if (hi > 64'sd2147483647)
            hi = 64'sd2147483647;
        span = hi - lo;
        if (span == 0)
            scale = 64'hFFFF_FFFF;
        else
            scale = (64'(NB - 1) << 32) / 64'(span) + 64'($urandom_range(0, 2));
        if (scale > 64'hFFFF_FFFF)
            scale = 64'hFFFF_FFFF;
        write_config(lo[31:0], hi[31:0], scale[31:0]);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        longint      lo;
        longint      hi;
        logic [63:0] span;
        int          sel;
        lo = longint'($signed(range_low_reg));
        hi = longint'($signed(range_high_reg));
        sel = $urandom_range(0, 99);
        if (hi < lo || sel >= 85)
            return $urandom;
        if (sel >= 78)
            return $urandom_range(0, 1) ? range_low_reg : range_high_reg;
        span = 64'(hi - lo) + 64'd1;
        return SAMPLE_W'(lo + longint'({$urandom, $urandom} % span));
    endfunction

    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        hist_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result beat with nothing pending: in_range %0d bin_value %0h batch_done %0d",
                       m_tuser, m_tdata, m_tlast);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                if (m_tuser !== want.in_range)
                begin
                    $error("in_range mismatch: expected %0d, actual %0d", want.in_range, m_tuser);
                    fail_count++;
                end
                if (m_tdata !== want.bin_value)
                begin
                    $error("bin_value mismatch: expected %0h, actual %0h",
                           want.bin_value, m_tdata);
                    fail_count++;
                end
                if (m_tlast !== want.batch_done)
                begin
                    $error("batch_done mismatch: expected %0d, actual %0d",
                           want.batch_done, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    task automatic test_reset_state();
        write_config(RANGE_LOW_RST, RANGE_HIGH_RST, BIN_SCALE_RST);
        send_beat(CMD_READ, 32'h0000_0000, 8'd0, 1'b0);
        send_beat(CMD_READ, 32'hFFFF_FFFF, 8'd255, 1'b1);
        send_beat(CMD_ACCUM, 32'h0000_0000, 8'd0, 1'b0);
        send_beat(CMD_ACCUM, 32'h0000_8000, 8'd0, 1'b0);
        send_beat(CMD_ACCUM, 32'h7FFF_FFFF, 8'd255, 1'b1);
        send_beat(CMD_ACCUM, 32'h8000_0000, 8'd0, 1'b1);
        send_beat(CMD_READ, 32'h0000_0000, 8'd0, 1'b0);
        send_beat(CMD_READ, 32'h0000_0000, 8'd1, 1'b0);
        send_beat(CMD_READ, 32'h0000_0000, 8'd255, 1'b0);
        send_beat(CMD_UNUSED, 32'hFFFF_FFFF, 8'd255, 1'b1);
        send_beat(CMD_CLEAR, 32'h0000_0000, 8'd0, 1'b0);
        send_beat(CMD_READ, 32'h0000_0000, 8'd255, 1'b0);
        drain_pipeline();
    endtask

    task automatic test_range_extremes();
        write_config(32'h8000_0000, 32'h7FFF_FFFF, 32'd255);
        send_beat(CMD_ACCUM, 32'h8000_0000, 8'd0, 1'b0);
        send_beat(CMD_ACCUM, 32'h7FFF_FFFF, 8'd0, 1'b0);
        send_beat(CMD_ACCUM, 32'h0000_0000, 8'd0, 1'b1);
        send_beat(CMD_READ, 32'h0, 8'd0, 1'b0);
        send_beat(CMD_READ, 32'h0, 8'd254, 1'b0);
        send_beat(CMD_READ, 32'h0, 8'd255, 1'b0);
        drain_pipeline();
        write_config(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_beat(CMD_ACCUM, 32'h8000_0001, 8'd0, 1'b0);
        send_beat(CMD_READ, 32'h0, 8'd255, 1'b0);
        drain_pipeline();
        write_config(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000);
        send_beat(CMD_ACCUM, 32'h7FFF_FFFF, 8'd0, 1'b1);
        send_beat(CMD_READ, 32'h0, 8'd0, 1'b0);
        drain_pipeline();
    endtask

    task automatic test_inverted_range();
        write_config(32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000);
        send_beat(CMD_ACCUM, 32'h0000_0000, 8'd0, 1'b1);
        send_beat(CMD_ACCUM, 32'h0001_0000, 8'd0, 1'b0);
        send_beat(CMD_READ, 32'h0, 8'd0, 1'b0);
        drain_pipeline();
    endtask

    task automatic test_random_stream();
        int               send_pcts [4];
        int               recv_pcts [4];
        int               sel;
        logic [CMD_W-1:0] cmd;
        send_pcts = '{0, 81, 0, 15};
        recv_pcts = '{0, 0, 81, 15};
        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct = send_pcts[phase];
            recv_stall_pct = recv_pcts[phase];
            for (int seg = 0; seg < 2; seg++)
            begin
                if (phase == 0 && seg == 0)
                    write_config(32'h8000_0000, 32'h7FFF_FFFF, 32'd255);
                else
                    random_config();
                for (int n = 0; n < 152; n++)
                begin
                    sel = $urandom_range(0, 99);
                    if (sel < 70)
                        cmd = CMD_ACCUM;
                    else if (sel < 92)
                        cmd = CMD_READ;
                    else if (sel < 95)
                        cmd = CMD_CLEAR;
                    else
                        cmd = CMD_UNUSED;
                    send_beat(cmd, pick_sample(), INDEX_W'($urandom),
                              ($urandom_range(0, 7) == 0));
                end
                drain_pipeline();
            end
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        s_tuser   <= '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        fail_count = 0;
        beats_sent = 0;
        results_checked = 0;
        samples_binned = 0;
        samples_dropped = 0;
        reads_sent = 0;
        clears_sent = 0;
        configs_written = 0;
        foreach (bin_totals[i])
            bin_totals[i] = '0;
        range_low_reg = RANGE_LOW_RST;
        range_high_reg = RANGE_HIGH_RST;
        bin_scale_reg = BIN_SCALE_RST;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_range_extremes();
        test_inverted_range();
        test_random_stream();

        drain_pipeline();
        if (pending_results.size() != 0)
        begin
            $error("%0d result beats never arrived", pending_results.size());
            fail_count++;
        end
        $display("Sent %0d beats under %0d range settings: %0d binned, %0d dropped, %0d reads, %0d clears",
                 beats_sent, configs_written, samples_binned, samples_dropped,
                 reads_sent, clears_sent);
        $display("Checked %0d result beats across four idle/stall mixes", results_checked);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: linear_weighted_histogram_core.f
+incdir+rtl/core
rtl/core/lwh_pkg.sv
rtl/core/lwh_front.sv
rtl/core/lwh_queue.sv
rtl/core/lwh_back.sv
rtl/core/linear_weighted_histogram_core.sv
dv/testbench.sv
